// ===== src/mmbf_pkg.sv =====
package mmbf_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_COEF_BITS = 16;

    // Tallest supported frame and the row counter that covers it plus the drain rows.
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 13;

    // Configuration port.
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 12'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd1024;

    // Request kinds.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

endpackage

// ===== src/mutual_masking_box_filter.sv =====
// Mutual masking box filter: 3x3 mean of min(|test_coef|, |ref_coef|) over a band image.
// Requests arrive on req_valid/req_ready in raster order, one pixel pair per request
// (kind = pixel), and after the last pixel of a frame the source sends image_width + 1
// flush requests (kind = flush) to drain the remaining results. Results leave on
// rsp_valid/rsp_ready; the result for pixel (r, c) is produced by the request that
// arrives one row and one pixel later, and the final result of a frame has last set.
// Image size is set through cfg_write/cfg_index/cfg_data only while the block is idle,
// a rule for the user that the block does not enforce. Throughput is one request per
// cycle unless the receiver stalls. The two line stores share one memory with a
// registered read; a request reads its column while the previous request writes back,
// and a same-column write is forwarded into the read data. The window sum, reciprocal
// multiply and output register stages follow, in that order, the accepting edge of the
// request that completes a neighborhood, at which the line store read is registered.
// Reset sets the image size to 1024 x 1024, returns to the first pixel of a frame and
// empties the pipeline; the line store memory needs no clearing pass.
// When the receiver stalls, the three internal stages and the output register keep
// taking requests until they fill; req_ready then drops until rsp_ready returns.
module mutual_masking_box_filter #(
    parameter int MAX_WIDTH = mmbf_pkg::DEF_MAX_WIDTH,
    parameter int COEF_BITS = mmbf_pkg::DEF_COEF_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [mmbf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mmbf_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                kind,
    input  logic signed [COEF_BITS-1:0]         test_coef,
    input  logic signed [COEF_BITS-1:0]         ref_coef,

    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [COEF_BITS-1:0]                masked,
    output logic                                last
);

    // Column counter indexes the line store; the compare width also covers image_width.
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int CMP_W   = (COL_W + 1 > mmbf_pkg::CFG_WIDTH_W) ? COL_W + 1
                                                                 : mmbf_pkg::CFG_WIDTH_W;
    localparam int ROW_W   = mmbf_pkg::ROW_W;
    localparam int MEM_W   = 2 * COEF_BITS;
    localparam int CS_W    = COEF_BITS + 2;   // one window column (three values)
    localparam int SUM_W   = COEF_BITS + 4;   // nine values plus the rounding offset

    // Division by nine: floor(n / 9) = (n * RECIP) >> SHIFT_K, exact for n < 2**SUM_W.
    localparam int SHIFT_K = SUM_W + 4;
    localparam int RECIP_W = SHIFT_K - 3;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT_K) + 64'd8) / 64'd9);

    // The multiply is split into two partial products that are summed one stage later.
    localparam int LO_W    = SUM_W / 2;
    localparam int HI_W    = SUM_W - LO_W;
    localparam int PLO_W   = LO_W + RECIP_W;
    localparam int PHI_W   = HI_W + RECIP_W;
    localparam int PROD_W  = SUM_W + RECIP_W;

    typedef struct packed {
        logic [COL_W-1:0]     addr;
        logic [COEF_BITS-1:0] v;
        logic                 top_en;
        logic                 mid_en;
        logic                 col0;
        logic                 emit;
        logic                 last;
    } s1_t;

    function automatic logic [COEF_BITS-1:0] coef_mag(input logic [COEF_BITS-1:0] raw);
        logic [COEF_BITS-1:0] m;
        // The most negative code maps onto itself, which read unsigned is its magnitude.
        m = raw[COEF_BITS-1] ? (~raw + COEF_BITS'(1)) : raw;
        return m;
    endfunction

    // Configuration registers.
    logic [mmbf_pkg::CFG_WIDTH_W-1:0]  width_reg;
    logic [mmbf_pkg::CFG_HEIGHT_W-1:0] height_reg;

    // Frame position of the next request.
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;

    // Line store memory: upper half holds the row two above, lower half the row above.
    logic [MEM_W-1:0] line_mem [MAX_WIDTH];
    logic [MEM_W-1:0] mem_q_reg;
    logic [MEM_W-1:0] wr_data;

    // Stage 1: line store data available, window update.
    logic             s1_valid_reg;
    s1_t              s1_reg;
    s1_t              s1_next;
    logic             s1_fwd_reg;
    logic [MEM_W-1:0] s1_fwd_data_reg;
    logic             s1_adv;

    // Window kept as the sums of its two older columns.
    logic [CS_W-1:0]  csa_reg;
    logic [CS_W-1:0]  csb_reg;

    // Stage 2: window sum, stage 3: partial products, then the output register.
    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic             s2_last_reg;
    logic             s2_adv;
    logic             s3_valid_reg;
    logic [PLO_W-1:0] s3_plo_reg;
    logic [PHI_W-1:0] s3_phi_reg;
    logic             s3_last_reg;
    logic             s3_adv;

    logic                 rsp_valid_reg;
    logic [COEF_BITS-1:0] masked_reg;
    logic                 last_reg;

    logic accept;

    // Effective image size.
    logic [CMP_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [ROW_W-1:0] h_plus1;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CMP_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            h_eff = ROW_W'(1);
        end
        else if (ROW_W'(height_reg) > ROW_W'(mmbf_pkg::MAX_HEIGHT))
        begin
            h_eff = ROW_W'(mmbf_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = ROW_W'(height_reg);
        end
        h_plus1 = h_eff + ROW_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mmbf_pkg::RST_IMAGE_WIDTH;
            height_reg <= mmbf_pkg::RST_IMAGE_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mmbf_pkg::REG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data[mmbf_pkg::CFG_WIDTH_W-1:0];
                end
                mmbf_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data[mmbf_pkg::CFG_HEIGHT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Stage 0: position bookkeeping for the incoming request.
    logic [COL_W-1:0]     c1;
    logic [COL_W-1:0]     c2;
    logic [ROW_W-1:0]     r1;
    logic [ROW_W-1:0]     r2;
    logic [CMP_W-1:0]     c3;
    logic [COEF_BITS-1:0] mag_t;
    logic [COEF_BITS-1:0] mag_r;

    always_comb
    begin
        // A column at or past the width (after a width change) starts the next row.
        if (CMP_W'(col_reg) >= w_eff)
        begin
            c1 = '0;
            r1 = row_reg + ROW_W'(1);
        end
        else
        begin
            c1 = col_reg;
            r1 = row_reg;
        end

        // A row beyond the drain rows restarts the frame.
        if (r1 > h_plus1)
        begin
            c2 = '0;
            r2 = '0;
        end
        else
        begin
            c2 = c1;
            r2 = r1;
        end

        mag_t = coef_mag(test_coef);
        mag_r = coef_mag(ref_coef);

        s1_next.addr   = c2;
        s1_next.v      = (kind == mmbf_pkg::KIND_PIXEL && r2 < h_eff)
                         ? ((mag_t < mag_r) ? mag_t : mag_r) : '0;
        s1_next.top_en = (r2 >= ROW_W'(2));
        s1_next.mid_en = (r2 != '0) && (r2 <= h_eff);
        s1_next.col0   = (c2 == '0);
        s1_next.emit   = s1_next.col0 ? s1_next.top_en : s1_next.mid_en;
        s1_next.last   = s1_next.col0 && (r2 == h_plus1);

        c3 = CMP_W'(c2) + CMP_W'(1);
        if (s1_next.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (c3 >= w_eff)
        begin
            col_next = '0;
            row_next = r2 + ROW_W'(1);
        end
        else
        begin
            col_next = c3[COL_W-1:0];
            row_next = r2;
        end
    end

    assign req_ready = !s1_valid_reg || s1_adv;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1 payload. When the request in stage 1 writes the column that the new
    // request reads in the same cycle, the written word is captured for forwarding.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg          <= s1_next;
            s1_fwd_reg      <= s1_valid_reg && (s1_reg.addr == c2);
            s1_fwd_data_reg <= wr_data;
        end
    end

    // Line store memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            line_mem[s1_reg.addr] <= wr_data;
        end
        if (accept)
        begin
            mem_q_reg <= line_mem[c2];
        end
    end

    // Stage 1: fetch neighbors, form the window sum.
    logic [MEM_W-1:0]     rd_word;
    logic [COEF_BITS-1:0] top;
    logic [COEF_BITS-1:0] mid;
    logic [CS_W-1:0]      new_col;
    logic [SUM_W-1:0]     win_sum;

    always_comb
    begin
        rd_word = s1_fwd_reg ? s1_fwd_data_reg : mem_q_reg;
        top     = s1_reg.top_en ? rd_word[MEM_W-1:COEF_BITS] : '0;
        mid     = s1_reg.mid_en ? rd_word[COEF_BITS-1:0] : '0;
        new_col = CS_W'(top) + CS_W'(mid) + CS_W'(s1_reg.v);
        // At the first column the window slides in zeros, so the new column is not summed.
        if (s1_reg.col0)
        begin
            win_sum = SUM_W'(csa_reg) + SUM_W'(csb_reg);
        end
        else
        begin
            win_sum = SUM_W'(csa_reg) + SUM_W'(csb_reg) + SUM_W'(new_col);
        end
        wr_data = {rd_word[COEF_BITS-1:0], s1_reg.v};
    end

    assign s1_adv = s1_valid_reg && (!s1_reg.emit || !s2_valid_reg || s2_adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csa_reg <= '0;
            csb_reg <= '0;
        end
        else if (s1_adv)
        begin
            if (s1_reg.last)
            begin
                csa_reg <= '0;
                csb_reg <= '0;
            end
            else if (s1_reg.col0)
            begin
                csa_reg <= '0;
                csb_reg <= new_col;
            end
            else
            begin
                csa_reg <= csb_reg;
                csb_reg <= new_col;
            end
        end
    end

    // Stage 2: round and multiply by the reciprocal of nine in two halves.
    logic [SUM_W-1:0] rnd_sum;

    assign rnd_sum = s2_sum_reg + SUM_W'(4);
    assign s2_adv  = s2_valid_reg && (!s3_valid_reg || s3_adv);
    assign s3_adv  = s3_valid_reg && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv && s1_reg.emit)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (s3_adv)
            begin
                s3_valid_reg <= 1'b0;
            end

            if (s3_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 3: combine the partial products and take the quotient.
    logic [PROD_W-1:0] prod;

    assign prod = (PROD_W'(s3_phi_reg) << LO_W) + PROD_W'(s3_plo_reg);

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_reg.emit)
        begin
            s2_sum_reg  <= win_sum;
            s2_last_reg <= s1_reg.last;
        end
        if (s2_adv)
        begin
            s3_plo_reg  <= PLO_W'(rnd_sum[LO_W-1:0]) * PLO_W'(RECIP);
            s3_phi_reg  <= PHI_W'(rnd_sum[SUM_W-1:LO_W]) * PHI_W'(RECIP);
            s3_last_reg <= s2_last_reg;
        end
        if (s3_adv)
        begin
            masked_reg <= prod[SHIFT_K +: COEF_BITS];
            last_reg   <= s3_last_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign masked    = masked_reg;
    assign last      = last_reg;

    // The request that closes a frame leaves the position at the frame start.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_next.last |=> col_reg == '0 && row_reg == '0)
        else $error("frame end did not return to the first pixel");

    // A read of the column that stage 1 writes back is always forwarded.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg && s1_reg.addr == c2 |=> s1_fwd_reg)
        else $error("same-column read was not forwarded");

    // A window sum held in stage 2 must not change until it moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_adv |=> s2_valid_reg && $stable(s2_sum_reg)
                                    && $stable(s2_last_reg))
        else $error("stalled window sum was lost or changed");

    // A mean of magnitudes never exceeds the largest magnitude.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> masked_reg <= (COEF_BITS'(1) << (COEF_BITS - 1)))
        else $error("mean out of range");

endmodule
